// ===== design/ddo_pkg.sv =====
`default_nettype none

package ddo_pkg;

  localparam int ANGLE_W     = 32;
  localparam int RADIUS_W    = 16;
  localparam int IWB_W       = 16;
  localparam int POS_W       = 32;
  localparam int HEAD_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int TRIG_W      = 18;
  localparam int CORDIC_W    = 32;
  localparam int TRIG_SHIFT  = 15;
  localparam int BAM_W       = 30;
  localparam int BAM_OUT_LSB = 40;
  localparam int ATAN_IDX_W  = 5;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RST         = 16'd2048;
  localparam logic [IWB_W-1:0]    INV_WHEEL_BASE_RST = 16'd1024;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 32'sh4000_0000;
  localparam logic [BAM_W-1:0] BAM_PER_RAD = 30'd683565276;

  typedef enum logic {
    REG_RADIUS         = 1'b0,
    REG_INV_WHEEL_BASE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] left_angle;
    logic signed [ANGLE_W-1:0] right_angle;
    logic                      restart;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [HEAD_W-1:0]       heading;
  } out_word_t;

  function automatic logic signed [CORDIC_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CORDIC_W-1:0] val;
    case (idx)
      5'd0: val = 32'sd536870912;
      5'd1: val = 32'sd316933406;
      5'd2: val = 32'sd167458907;
      5'd3: val = 32'sd85004756;
      5'd4: val = 32'sd42667331;
      5'd5: val = 32'sd21354465;
      5'd6: val = 32'sd10679838;
      5'd7: val = 32'sd5340245;
      5'd8: val = 32'sd2670163;
      5'd9: val = 32'sd1335087;
      5'd10: val = 32'sd667544;
      5'd11: val = 32'sd333772;
      5'd12: val = 32'sd166886;
      5'd13: val = 32'sd83443;
      5'd14: val = 32'sd41722;
      5'd15: val = 32'sd20861;
      5'd16: val = 32'sd10430;
      5'd17: val = 32'sd5215;
      5'd18: val = 32'sd2608;
      5'd19: val = 32'sd1304;
      5'd20: val = 32'sd652;
      5'd21: val = 32'sd326;
      5'd22: val = 32'sd163;
      5'd23: val = 32'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/ddo_ser_mul.sv =====
`default_nettype none

module ddo_ser_mul #(
  parameter int MCAND_W     = 8,
  parameter int MPLR_W      = 8,
  parameter bit MPLR_SIGNED = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MCAND_W-1:0] mcand,
  input  logic [MPLR_W-1:0]  mplr,
  output logic [MCAND_W-1:0] prod_hi,
  output logic [MPLR_W-1:0]  prod_lo
);

  localparam int CNT_W = $clog2(MPLR_W + 1);

  logic [MCAND_W-1:0] acc_r, acc_nxt;
  logic [MPLR_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MCAND_W:0]   addend;
  logic [MCAND_W:0]   acc_ext;
  logic [MCAND_W:0]   total;
  logic               last_neg;

  // The multiplier bits leave q_r at the bottom while the low product bits enter at the top.
  always_comb begin
    last_neg = MPLR_SIGNED && (cnt_r == CNT_W'(1));
    addend   = q_r[0] ? {mcand[MCAND_W-1], mcand} : '0;
    acc_ext  = {acc_r[MCAND_W-1], acc_r};
    total    = last_neg ? (acc_ext - addend) : (acc_ext + addend);
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      acc_nxt = '0;
      q_nxt   = mplr;
      cnt_nxt = CNT_W'(MPLR_W);
    end else if (cnt_r != '0) begin
      acc_nxt = total[MCAND_W:1];
      q_nxt   = {total[0], q_r[MPLR_W-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
  end

  assign prod_hi = acc_r;
  assign prod_lo = q_r;

endmodule

`default_nettype wire

// ===== design/differential_drive_odometry.sv =====
`default_nettype none
// Port group   Direction  Handshake                         Word
// in_          input      in_valid, in_stall                ddo_pkg::in_word_t
// out_         output     out_valid, out_stall              ddo_pkg::out_word_t
// APB          in/out     psel, penable, pwrite, pready     radius at 0x0, inv_wheel_base at 0x4
//
// A word goes through the sum, first multiply, round, second multiply and done states before the
// next word is accepted, paced by the bit-serial multipliers and the CORDIC iterations that share
// a phase. The result is registered into the output word as the done state is left.
// Reset is synchronous and active low; it clears the pose and the previous angles and loads
// the registers with 2048 and 1024.
// A word is accepted while a result still waits under out_stall; the next result then holds
// in the last phase until the output register is free.

module differential_drive_odometry #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ddo_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ddo_pkg::out_word_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ddo_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ddo_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int AW       = ddo_pkg::ANGLE_W;
  localparam int RW       = ddo_pkg::RADIUS_W;
  localparam int IW       = ddo_pkg::IWB_W;
  localparam int PW       = ddo_pkg::POS_W;
  localparam int HW       = ddo_pkg::HEAD_W;
  localparam int FW       = ddo_pkg::FRAC_W;
  localparam int TW       = ddo_pkg::TRIG_W;
  localparam int CW       = ddo_pkg::CORDIC_W;
  localparam int DSUM_W   = AW + 1;
  localparam int WSUM_W   = DSUM_W + 1;
  localparam int KMC_W    = ddo_pkg::BAM_W + 1;
  localparam int KP_W     = ddo_pkg::BAM_W + IW;
  localparam int HMC_W    = KP_W + 1;
  localparam int XSTEP_W  = WSUM_W + TW - FW;
  localparam int SAT_W    = XSTEP_W + 1;
  localparam int BAM_LSB  = ddo_pkg::BAM_OUT_LSB - WSUM_W;
  localparam int TX_W     = CW + 1;
  localparam int MUL1_LEN = (ANGLE_BITS > RW) ? ANGLE_BITS : RW;
  localparam int MUL2_LEN = WSUM_W;
  localparam int CNT_W    = $clog2((MUL1_LEN > MUL2_LEN) ? MUL1_LEN : MUL2_LEN);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_RND  = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic seen_first_r, seen_first_nxt;
  logic [AW-1:0] prev_left_r, prev_left_nxt;
  logic [AW-1:0] prev_right_r, prev_right_nxt;
  logic [PW-1:0] pose_x_r, pose_x_nxt;
  logic [PW-1:0] pose_y_r, pose_y_nxt;
  logic [HW-1:0] pose_head_r, pose_head_nxt;
  logic [RW-1:0] radius_r;
  logic [IW-1:0] inv_wheel_base_r;
  logic out_valid_r, out_valid_nxt;
  ddo_pkg::out_word_t out_data_r, out_data_nxt;

  logic [AW-1:0] delta_l_r, delta_l_nxt;
  logic [AW-1:0] delta_r_r, delta_r_nxt;
  logic [DSUM_W-1:0] dsum_r, dsum_nxt;
  logic [DSUM_W-1:0] ddif_r, ddif_nxt;
  logic [WSUM_W-1:0] sum16_r, sum16_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt;
  logic signed [CW-1:0] cy_r, cy_nxt;
  logic signed [CW-1:0] cz_r, cz_nxt;
  logic flip_r, flip_nxt;

  logic accept;
  logic first_word;
  logic cfg_wr;
  logic mul1_start;
  logic mul2_start;
  logic [ddo_pkg::ATAN_IDX_W-1:0] shamt;
  logic signed [CW-1:0] xsh;
  logic signed [CW-1:0] ysh;
  logic signed [CW-1:0] atan_w;
  logic signed [CW-1:0] z0;
  logic [TX_W-1:0] tx_w;
  logic [TX_W-1:0] ty_w;
  logic [TW-1:0] c15_w;
  logic [TW-1:0] s15_w;

  logic [DSUM_W-1:0] sum_hi;
  logic [RW-1:0] sum_lo;
  logic [DSUM_W-1:0] dif_hi;
  logic [RW-1:0] dif_lo;
  logic [KMC_W-1:0] kp_hi;
  logic [IW-1:0] kp_lo;
  logic [WSUM_W-1:0] x_hi;
  logic [TW-1:0] x_lo;
  logic [WSUM_W-1:0] y_hi;
  logic [TW-1:0] y_lo;
  logic [HMC_W-1:0] h_hi;
  logic [WSUM_W-1:0] h_lo;

  logic [WSUM_W-1:0] sum16_w;
  logic [WSUM_W-1:0] dif16_w;
  logic [HMC_W-1:0] h_mcand;
  logic [SAT_W-1:0] new_x;
  logic [SAT_W-1:0] new_y;
  logic [HW-1:0] dhead;
  logic [HW-1:0] new_head;

  function automatic logic [PW-1:0] sat_pos(input logic [SAT_W-1:0] v);
    logic [PW-1:0] res;
    if (v[SAT_W-1:PW-1] == {(SAT_W-PW+1){v[SAT_W-1]}}) begin
      res = v[PW-1:0];
    end else if (v[SAT_W-1]) begin
      res = {1'b1, {(PW-1){1'b0}}};
    end else begin
      res = {1'b0, {(PW-1){1'b1}}};
    end
    return res;
  endfunction

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign first_word = in_data.restart || !seen_first_r;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign mul1_start = (state_r == ST_SUM);
  assign mul2_start = (state_r == ST_RND);

  always_comb begin
    case (ddo_pkg::reg_idx_t'(paddr[2]))
      ddo_pkg::REG_RADIUS:         prdata = {{(ddo_pkg::CFG_DATA_W-RW){1'b0}}, radius_r};
      ddo_pkg::REG_INV_WHEEL_BASE: prdata = {{(ddo_pkg::CFG_DATA_W-IW){1'b0}}, inv_wheel_base_r};
      default:                     prdata = '0;
    endcase
  end

  ddo_ser_mul #(.MCAND_W(DSUM_W), .MPLR_W(RW), .MPLR_SIGNED(1'b0)) u_mul_sum (
    .clk(clk), .rst_n(rst_n), .start(mul1_start), .mcand(dsum_r), .mplr(radius_r),
    .prod_hi(sum_hi), .prod_lo(sum_lo)
  );

  ddo_ser_mul #(.MCAND_W(DSUM_W), .MPLR_W(RW), .MPLR_SIGNED(1'b0)) u_mul_dif (
    .clk(clk), .rst_n(rst_n), .start(mul1_start), .mcand(ddif_r), .mplr(radius_r),
    .prod_hi(dif_hi), .prod_lo(dif_lo)
  );

  ddo_ser_mul #(.MCAND_W(KMC_W), .MPLR_W(IW), .MPLR_SIGNED(1'b0)) u_mul_kp (
    .clk(clk), .rst_n(rst_n), .start(mul1_start), .mcand({1'b0, ddo_pkg::BAM_PER_RAD}),
    .mplr(inv_wheel_base_r), .prod_hi(kp_hi), .prod_lo(kp_lo)
  );

  ddo_ser_mul #(.MCAND_W(WSUM_W), .MPLR_W(TW), .MPLR_SIGNED(1'b1)) u_mul_x (
    .clk(clk), .rst_n(rst_n), .start(mul2_start), .mcand(sum16_r), .mplr(c15_w),
    .prod_hi(x_hi), .prod_lo(x_lo)
  );

  ddo_ser_mul #(.MCAND_W(WSUM_W), .MPLR_W(TW), .MPLR_SIGNED(1'b1)) u_mul_y (
    .clk(clk), .rst_n(rst_n), .start(mul2_start), .mcand(sum16_r), .mplr(s15_w),
    .prod_hi(y_hi), .prod_lo(y_lo)
  );

  ddo_ser_mul #(.MCAND_W(HMC_W), .MPLR_W(WSUM_W), .MPLR_SIGNED(1'b1)) u_mul_h (
    .clk(clk), .rst_n(rst_n), .start(mul2_start), .mcand(h_mcand), .mplr(dif16_w),
    .prod_hi(h_hi), .prod_lo(h_lo)
  );

  assign sum16_w = {sum_hi[DSUM_W-1], sum_hi} + {{(WSUM_W-1){1'b0}}, sum_lo[FW-1]};
  assign dif16_w = {dif_hi[DSUM_W-1], dif_hi} + {{(WSUM_W-1){1'b0}}, dif_lo[FW-1]};
  assign h_mcand = {1'b0, kp_hi[KMC_W-2:0], kp_lo};

  // A folded heading returns the negated vector, rounded after negation.
  assign tx_w  = flip_r ? ({~cx_r[CW-1], ~cx_r} + TX_W'(33'd16385))
                        : ({cx_r[CW-1], cx_r} + TX_W'(33'd16384));
  assign ty_w  = flip_r ? ({~cy_r[CW-1], ~cy_r} + TX_W'(33'd16385))
                        : ({cy_r[CW-1], cy_r} + TX_W'(33'd16384));
  assign c15_w = tx_w[TX_W-1:ddo_pkg::TRIG_SHIFT];
  assign s15_w = ty_w[TX_W-1:ddo_pkg::TRIG_SHIFT];

  assign shamt  = cnt_r[ddo_pkg::ATAN_IDX_W-1:0];
  assign xsh    = cx_r >>> shamt;
  assign ysh    = cy_r >>> shamt;
  assign atan_w = ddo_pkg::atan_val(shamt);
  assign z0     = {pose_head_r, {(CW-HW){1'b0}}};

  assign new_x = {{(SAT_W-PW){pose_x_r[PW-1]}}, pose_x_r}
               + {x_hi[WSUM_W-1], x_hi, x_lo[TW-1:FW]}
               + {{(SAT_W-1){1'b0}}, x_lo[FW-1]};
  assign new_y = {{(SAT_W-PW){pose_y_r[PW-1]}}, pose_y_r}
               + {y_hi[WSUM_W-1], y_hi, y_lo[TW-1:FW]}
               + {{(SAT_W-1){1'b0}}, y_lo[FW-1]};
  assign dhead    = h_hi[BAM_LSB+HW-1:BAM_LSB] + {{(HW-1){1'b0}}, h_hi[BAM_LSB-1]};
  assign new_head = pose_head_r + dhead;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    seen_first_nxt = seen_first_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    pose_x_nxt     = pose_x_r;
    pose_y_nxt     = pose_y_r;
    pose_head_nxt  = pose_head_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    delta_l_nxt    = delta_l_r;
    delta_r_nxt    = delta_r_r;
    dsum_nxt       = dsum_r;
    ddif_nxt       = ddif_r;
    sum16_nxt      = sum16_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    flip_nxt       = flip_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          seen_first_nxt = 1'b1;
          prev_left_nxt  = in_data.left_angle;
          prev_right_nxt = in_data.right_angle;
          if (first_word) begin
            delta_l_nxt   = '0;
            delta_r_nxt   = '0;
            pose_x_nxt    = '0;
            pose_y_nxt    = '0;
            pose_head_nxt = '0;
          end else begin
            delta_l_nxt = in_data.left_angle - prev_left_r;
            delta_r_nxt = in_data.right_angle - prev_right_r;
          end
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        dsum_nxt = {delta_r_r[AW-1], delta_r_r} + {delta_l_r[AW-1], delta_l_r};
        ddif_nxt = {delta_r_r[AW-1], delta_r_r} - {delta_l_r[AW-1], delta_l_r};
        cx_nxt   = ddo_pkg::CORDIC_GAIN;
        cy_nxt   = '0;
        if ((z0 > ddo_pkg::QUARTER_TURN) || (z0 < -ddo_pkg::QUARTER_TURN)) begin
          cz_nxt   = {~z0[CW-1], z0[CW-2:0]};
          flip_nxt = 1'b1;
        end else begin
          cz_nxt   = z0;
          flip_nxt = 1'b0;
        end
        cnt_nxt   = '0;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        if (cnt_r < CNT_W'(ANGLE_BITS)) begin
          if (!cz_r[CW-1]) begin
            cx_nxt = cx_r - ysh;
            cy_nxt = cy_r + xsh;
            cz_nxt = cz_r - atan_w;
          end else begin
            cx_nxt = cx_r + ysh;
            cy_nxt = cy_r - xsh;
            cz_nxt = cz_r + atan_w;
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL1_LEN - 1)) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        sum16_nxt = sum16_w;
        cnt_nxt   = '0;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL2_LEN - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          pose_x_nxt           = sat_pos(new_x);
          pose_y_nxt           = sat_pos(new_y);
          pose_head_nxt        = new_head;
          out_data_nxt.x_pos   = sat_pos(new_x);
          out_data_nxt.y_pos   = sat_pos(new_y);
          out_data_nxt.heading = new_head;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      cnt_r            <= '0;
      seen_first_r     <= 1'b0;
      prev_left_r      <= '0;
      prev_right_r     <= '0;
      pose_x_r         <= '0;
      pose_y_r         <= '0;
      pose_head_r      <= '0;
      out_valid_r      <= 1'b0;
      radius_r         <= ddo_pkg::RADIUS_RST;
      inv_wheel_base_r <= ddo_pkg::INV_WHEEL_BASE_RST;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      seen_first_r <= seen_first_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      pose_x_r     <= pose_x_nxt;
      pose_y_r     <= pose_y_nxt;
      pose_head_r  <= pose_head_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr) begin
        case (ddo_pkg::reg_idx_t'(paddr[2]))
          ddo_pkg::REG_RADIUS:         radius_r         <= pwdata[RW-1:0];
          ddo_pkg::REG_INV_WHEEL_BASE: inv_wheel_base_r <= pwdata[IW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    delta_l_r  <= delta_l_nxt;
    delta_r_r  <= delta_r_nxt;
    dsum_r     <= dsum_nxt;
    ddif_r     <= ddif_nxt;
    sum16_r    <= sum16_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    flip_r     <= flip_nxt;
  end

endmodule

`default_nettype wire

// ===== design/ddo_checker.sv =====
`default_nettype none

module ddo_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ddo_pkg::out_word_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input accepted again while a word is in work");

  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("new result word without the input side free");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);

`default_nettype wire

// ===== dv/differential_drive_odometry_tb.sv =====
`default_nettype none

module differential_drive_odometry_tb;

  localparam int CORDIC_STEPS = 16;
  localparam int CYCLE_LIMIT = 800000;
  localparam longint POS_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint POS_MIN = -POS_MAX - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ddo_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ddo_pkg::out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ddo_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [ddo_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [ddo_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  differential_drive_odometry #(
    .ANGLE_BITS(CORDIC_STEPS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  longint atan_q32 [0:15] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic [15:0] radius_q16 = ddo_pkg::RADIUS_RST;
  logic [15:0] inv_base_q8 = ddo_pkg::INV_WHEEL_BASE_RST;
  logic [31:0] last_left = '0;
  logic [31:0] last_right = '0;
  longint pose_x = 0;
  longint pose_y = 0;
  logic [15:0] pose_head = '0;
  bit have_sample = 1'b0;

  ddo_pkg::out_word_t pose_expect_q [$];
  int err_cnt = 0;
  int words_sent = 0;
  int poses_checked = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_cnt = 0;
  logic [31:0] walk_left = '0;
  logic [31:0] walk_right = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.", cycle_cnt,
               pose_expect_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  task automatic heading_trig(input logic [15:0] head, output longint cos15, output longint sin15);
    longint z, cx, cy, nx;
    bit flip;
    z = longint'($signed({head, 16'h0000}));
    cx = 652032874;
    cy = 0;
    flip = 1'b0;
    if (z > (longint'(1) <<< 30)) begin
      z = z - (longint'(1) <<< 31);
      flip = 1'b1;
    end else if (z < -(longint'(1) <<< 30)) begin
      z = z + (longint'(1) <<< 31);
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z = z - atan_q32[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z = z + atan_q32[i];
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cos15 = round_shift(cx, 15);
    sin15 = round_shift(cy, 15);
  endtask

  task automatic odometry_advance(input ddo_pkg::in_word_t w, output ddo_pkg::out_word_t pose);
    logic [31:0] dlw, drw;
    longint dl, dr, sum16, dif16, cos15, sin15, rad24;
    longint unsigned bam;
    if (w.restart || !have_sample) begin
      pose_x = 0;
      pose_y = 0;
      pose_head = '0;
      last_left = w.left_angle;
      last_right = w.right_angle;
      have_sample = 1'b1;
    end
    dlw = w.left_angle - last_left;
    drw = w.right_angle - last_right;
    dl = longint'($signed(dlw)) * longint'(radius_q16);
    dr = longint'($signed(drw)) * longint'(radius_q16);
    last_left = w.left_angle;
    last_right = w.right_angle;
    sum16 = round_shift(dr + dl, 16);
    dif16 = round_shift(dr - dl, 16);
    heading_trig(pose_head, cos15, sin15);
    pose_x = clamp_pos(pose_x + round_shift(sum16 * cos15, 16));
    pose_y = clamp_pos(pose_y + round_shift(sum16 * sin15, 16));
    rad24 = dif16 * longint'(inv_base_q8);
    bam = rad24;
    bam = bam * 64'd683565276;
    bam = bam + (64'd1 << 39);
    pose_head = pose_head + bam[55:40];
    pose.x_pos = pose_x[31:0];
    pose.y_pos = pose_y[31:0];
    pose.heading = pose_head;
  endtask

  function automatic ddo_pkg::in_word_t wheel_sample(logic [31:0] l, logic [31:0] r, logic rs);
    ddo_pkg::in_word_t w;
    w.left_angle = l;
    w.right_angle = r;
    w.restart = rs;
    return w;
  endfunction

  task automatic note_error(input string msg);
    if (err_cnt < 10) $display("MISMATCH: %s", msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin : check_results
    ddo_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_expect_q.size() == 0) begin
        note_error($sformatf("unexpected result x=%0d y=%0d heading=%0d",
                             out_data.x_pos, out_data.y_pos, out_data.heading));
      end else begin
        want = pose_expect_q.pop_front();
        poses_checked++;
        if (out_data.x_pos !== want.x_pos)
          note_error($sformatf("x_pos expected %0d got %0d", want.x_pos, out_data.x_pos));
        if (out_data.y_pos !== want.y_pos)
          note_error($sformatf("y_pos expected %0d got %0d", want.y_pos, out_data.y_pos));
        if (out_data.heading !== want.heading)
          note_error($sformatf("heading expected %0d got %0d", want.heading, out_data.heading));
      end
    end
  end

  task automatic send_sample(input ddo_pkg::in_word_t w);
    ddo_pkg::out_word_t pose;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    odometry_advance(w, pose);
    pose_expect_q.push_back(pose);
    words_sent++;
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (pose_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input ddo_pkg::reg_idx_t idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == ddo_pkg::REG_RADIUS) radius_q16 = val;
    else inv_base_q8 = val;
  endtask

  task automatic check_register(input ddo_pkg::reg_idx_t idx, input logic [15:0] val);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== {16'h0000, val})
      note_error($sformatf("register %s expected %0d got %0d", idx.name(), val, got));
  endtask

  task automatic apply_setting(input logic [15:0] radius, input logic [15:0] inv_base);
    wait_drained(4);
    cfg_write(ddo_pkg::REG_RADIUS, radius);
    cfg_write(ddo_pkg::REG_INV_WHEEL_BASE, inv_base);
    check_register(ddo_pkg::REG_RADIUS, radius);
    check_register(ddo_pkg::REG_INV_WHEEL_BASE, inv_base);
    settings_used++;
  endtask

  task automatic test_register_reset();
    check_register(ddo_pkg::REG_RADIUS, ddo_pkg::RADIUS_RST);
    check_register(ddo_pkg::REG_INV_WHEEL_BASE, ddo_pkg::INV_WHEEL_BASE_RST);
  endtask

  task automatic test_directed_extremes();
    logic [31:0] l, r;
    send_sample(wheel_sample(32'h1234_5678, 32'h9ABC_DEF0, 1'b0));
    send_sample(wheel_sample(32'h1235_5678, 32'h9ABD_DEF0, 1'b0));
    send_sample(wheel_sample(32'h1234_5678, 32'h9ABE_DEF0, 1'b0));
    send_sample(wheel_sample(32'h7FFF_0000, 32'h8000_FFFF, 1'b1));
    send_sample(wheel_sample(32'h8000_FFFF, 32'h7FFF_0000, 1'b0));
    send_sample(wheel_sample(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
    send_sample(wheel_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));

    apply_setting(16'hFFFF, 16'hFFFF);
    l = '0;
    r = '0;
    send_sample(wheel_sample(l, r, 1'b1));
    repeat (3) begin
      l += 32'h7FFF_FFFF;
      r += 32'h7FFF_FFFF;
      send_sample(wheel_sample(l, r, 1'b0));
    end
    repeat (4) begin
      l += 32'h8000_0000;
      r += 32'h8000_0000;
      send_sample(wheel_sample(l, r, 1'b0));
    end
    repeat (2) begin
      l += 32'h8000_0000;
      r += 32'h7FFF_FFFF;
      send_sample(wheel_sample(l, r, 1'b0));
    end

    apply_setting(16'h0000, 16'h0000);
    send_sample(wheel_sample(32'h4000_0000, 32'hC000_0000, 1'b0));
    send_sample(wheel_sample(32'h8000_0000, 32'h8000_0000, 1'b0));

    apply_setting(16'h0001, 16'h0001);
    send_sample(wheel_sample(32'h0000_0000, 32'h0000_0000, 1'b1));
    send_sample(wheel_sample(32'h0000_8000, 32'h0000_8000, 1'b0));
  endtask

  task automatic drive_random_walk(input int n);
    logic [31:0] span, dl, dr;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        walk_left = $urandom;
        walk_right = $urandom;
        send_sample(wheel_sample(walk_left, walk_right, 1'b1));
      end else if (kind < 12) begin
        walk_left = $urandom;
        walk_right = $urandom;
        send_sample(wheel_sample(walk_left, walk_right, 1'($urandom_range(0, 1))));
      end else begin
        case ($urandom_range(0, 3))
          0: span = 32'd255;
          1: span = 32'h0001_0000;
          2: span = 32'h0040_0000;
          default: span = 32'h4000_0000;
        endcase
        dl = $urandom_range(0, 2 * span) - span;
        if ($urandom_range(0, 1)) dr = dl + $urandom_range(0, 510) - 32'd255;
        else dr = $urandom_range(0, 2 * span) - span;
        walk_left += dl;
        walk_right += dr;
        send_sample(wheel_sample(walk_left, walk_right, 1'b0));
      end
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 18;
    recv_stall_pct = 50;
    apply_setting(ddo_pkg::RADIUS_RST, ddo_pkg::INV_WHEEL_BASE_RST);
    drive_random_walk(190);
    apply_setting(16'hFFFF, 16'hFFFF);
    drive_random_walk(190);

    send_idle_pct = 50;
    recv_stall_pct = 18;
    apply_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
    drive_random_walk(190);
    apply_setting(16'hFFFF, 16'h0000);
    drive_random_walk(190);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_setting(16'($urandom_range(0, 4095)), 16'hFFFF);
    drive_random_walk(190);
    apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    drive_random_walk(190);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_directed_extremes();
    test_random_traffic();

    wait_drained(60);
    if (pose_expect_q.size() != 0)
      note_error($sformatf("%0d results never arrived", pose_expect_q.size()));
    $display("Sent %0d wheel samples and compared %0d poses over %0d register settings,",
             words_sent, poses_checked, settings_used);
    $display("including radius and inverse base extremes and three stall mixes.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Total mismatches: %0d", err_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/ddo_pkg.sv
design/ddo_ser_mul.sv
design/differential_drive_odometry.sv
design/ddo_checker.sv
dv/differential_drive_odometry_tb.sv
